// File: src/rcfp_pkg.sv
// ----------------------------------------------------------------------------
// rcfp_pkg
// Shared types, constants and servo scaling for the receiver frame parser.
// ----------------------------------------------------------------------------
package rcfp_pkg;

	// Framing bytes
	localparam logic [7:0] SYNC_BYTE    = 8'hFF;
	localparam logic [7:0] HDR_STATUS   = 8'h1F;
	localparam logic [7:0] HDR_SCAN     = 8'hE3;
	localparam logic [7:0] HDR_TYPE_MSK = 8'hF0;
	localparam logic [7:0] HDR_SERVO    = 8'h10;
	localparam logic [7:0] SUM_ALT      = 8'hFE;

	// Frame lengths and frame store depth
	localparam logic [5:0] LEN_STATUS = 6'd5;
	localparam logic [5:0] LEN_SERVO  = 6'd4;
	localparam logic [5:0] LEN_SCAN   = 6'd48;
	localparam int         FRAME_KEEP = 5;
	localparam logic [3:0] PAIR_COUNT = 4'd10;

	// Register reset
	localparam logic [7:0] RSSI_THR_RESET = 8'd7;

	// Servo scaling: divide by 6 through a reciprocal; magnitudes at or above
	// 6 * 513 always clamp, so only 12 bits of magnitude reach the multiplier.
	localparam logic [15:0] SERVO_NEUTRAL = 16'd11059;
	localparam logic [15:0] SERVO_CLAMP   = 16'd3078;
	localparam logic [11:0] DIV6_RECIP    = 12'd2731;
	localparam logic [9:0]  QUOT_LIMIT    = 10'd512;

	// Result codes
	typedef enum logic [2:0] {
		ST_NONE    = 3'd0,
		ST_STATUS  = 3'd1,
		ST_SERVO   = 3'd2,
		ST_RANGE   = 3'd3,
		ST_UNKNOWN = 3'd4,
		ST_CHKSUM  = 3'd5
	} frame_status_t;

	// Big-endian word -> offset, /6 toward zero, *4, clamp to +-2048
	function automatic logic signed [12:0] scale_servo(input logic [7:0] hi,
	                                                   input logic [7:0] lo);
		logic [15:0] diff;
		logic        neg;
		logic [15:0] mag;
		logic [23:0] prod;
		logic [9:0]  quot;
		logic [12:0] val;
		diff = {hi, lo} - SERVO_NEUTRAL;
		neg  = diff[15];
		mag  = neg ? (16'd0 - diff) : diff;
		prod = mag[11:0] * DIV6_RECIP;
		if (mag >= SERVO_CLAMP) begin
			quot = QUOT_LIMIT;
		end else begin
			quot = prod[23:14];
		end
		val = {1'b0, quot, 2'b00};
		return neg ? signed'(13'd0 - val) : signed'(val);
	endfunction

endpackage

// File: src/rcfp_if.sv
// ----------------------------------------------------------------------------
// rcfp channel interfaces
// Byte request channel and result request channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface rcfp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink   (input valid, input data_byte, output ready);
endinterface

interface rcfp_result_if;
	logic               valid;
	logic               ready;
	logic [2:0]         frame_status;
	logic [3:0]         first_channel;
	logic signed [12:0] channel_a;
	logic signed [12:0] channel_b;
	logic [7:0]         band_allocation;
	logic [7:0]         receiver_channel;
	logic [7:0]         signal_strength;
	logic [7:0]         battery_level;
	logic               signal_ok;
	logic [31:0]        bad_checksum_count;
	logic [31:0]        unknown_frame_count;

	modport source (output valid, output frame_status, output first_channel,
	                output channel_a, output channel_b, output band_allocation,
	                output receiver_channel, output signal_strength,
	                output battery_level, output signal_ok,
	                output bad_checksum_count, output unknown_frame_count,
	                input ready);
	modport sink   (input valid, input frame_status, input first_channel,
	                input channel_a, input channel_b, input band_allocation,
	                input receiver_channel, input signal_strength,
	                input battery_level, input signal_ok,
	                input bad_checksum_count, input unknown_frame_count,
	                output ready);
endinterface

// File: src/rc_receiver_frame_parser_top.sv
// A byte accepted into the byte register has its result loaded into the result
// register once that stage can load, and waits while a finished result is unread.
// Throughput: one byte per cycle unless results stall; the byte register and
// result register form two stages: a free byte stage takes a byte while a result waits.
// Reset (arst_n low, asynchronous): parser state, stored values and counters
// clear to zero, the RSSI threshold returns to 7, both stages empty.
// ----------------------------------------------------------------------------
// rc_receiver_frame_parser_top
// Byte-serial receiver frame parser: resync, header decode, checksum, status
// frame storage, servo pair scaling and error counting.
// ----------------------------------------------------------------------------
module rc_receiver_frame_parser_top (
	input  logic                  clk,
	input  logic                  arst_n,
	rcfp_byte_if.sink             rx,
	rcfp_result_if.source         result,
	input  logic                  cfg_we,
	input  logic [7:0]            cfg_wdata
);

	localparam int FRAME_KEEP_L = rcfp_pkg::FRAME_KEEP;

	// Threshold register
	logic [7:0] rssi_thr_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rssi_thr_q <= rcfp_pkg::RSSI_THR_RESET;
		end else if (cfg_we) begin
			rssi_thr_q <= cfg_wdata;
		end
	end

	// Handshake: byte stage advances when the result stage can load
	logic       byte_valid_s1;
	logic [7:0] byte_s1;
	logic       res_valid_q;
	logic       res_load;
	logic       step;

	assign res_load = !res_valid_q || result.ready;
	assign rx.ready = !byte_valid_s1 || res_load;
	assign step     = byte_valid_s1 && res_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			byte_valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.data_byte;
		end
	end

	// Parser state
	logic [7:0]  prev_q;
	logic [5:0]  idx_q;
	logic [7:0]  sum_q;
	logic [5:0]  exp_len_q;
	logic [7:0]  fb_q [FRAME_KEEP_L];
	logic [7:0]  band_q;
	logic [7:0]  rxch_q;
	logic [7:0]  rssi_q;
	logic [7:0]  batt_q;
	logic [31:0] bad_cnt_q;
	logic [31:0] unk_cnt_q;

	// Byte decode
	logic                    resync;
	logic [5:0]              exp_len_d;
	logic                    at_chk;
	logic [7:0]              chk_exp;
	logic                    chk_ok;
	logic [7:0]              hdr;
	logic                    hdr_servo;
	logic                    pair_ok;
	rcfp_pkg::frame_status_t status_d;

	assign resync    = (byte_s1 == rcfp_pkg::SYNC_BYTE) && (prev_q == rcfp_pkg::SYNC_BYTE);
	assign at_chk    = (byte_s1 != rcfp_pkg::SYNC_BYTE) && (idx_q > exp_len_d);
	assign chk_exp   = (~sum_q == rcfp_pkg::SYNC_BYTE) ? rcfp_pkg::SUM_ALT : ~sum_q;
	assign chk_ok    = (byte_s1 == chk_exp);
	assign hdr       = fb_q[0];
	assign hdr_servo = ((hdr & rcfp_pkg::HDR_TYPE_MSK) == rcfp_pkg::HDR_SERVO);
	assign pair_ok   = (hdr[3:0] < rcfp_pkg::PAIR_COUNT);

	// Header sets the frame length; unknown headers keep the old one
	always_comb begin
		exp_len_d = exp_len_q;
		if (idx_q == 6'd0) begin
			priority if (byte_s1 == rcfp_pkg::HDR_STATUS) begin
				exp_len_d = rcfp_pkg::LEN_STATUS;
			end else if ((byte_s1 & rcfp_pkg::HDR_TYPE_MSK) == rcfp_pkg::HDR_SERVO) begin
				exp_len_d = rcfp_pkg::LEN_SERVO;
			end else if (byte_s1 == rcfp_pkg::HDR_SCAN) begin
				exp_len_d = rcfp_pkg::LEN_SCAN;
			end else begin
				exp_len_d = exp_len_q;
			end
		end
	end

	// Frame outcome at the checksum byte
	always_comb begin
		status_d = rcfp_pkg::ST_NONE;
		if (!resync && at_chk) begin
			priority if (!chk_ok) begin
				status_d = rcfp_pkg::ST_CHKSUM;
			end else if (hdr == rcfp_pkg::HDR_STATUS) begin
				status_d = rcfp_pkg::ST_STATUS;
			end else if (hdr_servo && pair_ok) begin
				status_d = rcfp_pkg::ST_SERVO;
			end else if (hdr_servo) begin
				status_d = rcfp_pkg::ST_RANGE;
			end else begin
				status_d = rcfp_pkg::ST_UNKNOWN;
			end
		end
	end

	// Next values of stored fields, shown in this step's result
	logic [7:0]  band_d, rxch_d, rssi_d, batt_d;
	logic [31:0] bad_cnt_d, unk_cnt_d;
	logic        is_servo;

	assign is_servo  = (status_d == rcfp_pkg::ST_SERVO);
	assign band_d    = (status_d == rcfp_pkg::ST_STATUS) ? fb_q[1] : band_q;
	assign rxch_d    = (status_d == rcfp_pkg::ST_STATUS) ? fb_q[2] : rxch_q;
	assign rssi_d    = (status_d == rcfp_pkg::ST_STATUS) ? fb_q[3] : rssi_q;
	assign batt_d    = (status_d == rcfp_pkg::ST_STATUS) ? fb_q[4] : batt_q;
	assign bad_cnt_d = bad_cnt_q + 32'((status_d == rcfp_pkg::ST_CHKSUM));
	assign unk_cnt_d = unk_cnt_q + 32'((status_d == rcfp_pkg::ST_UNKNOWN));

	// Parser state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q    <= '0;
			idx_q     <= '0;
			sum_q     <= '0;
			exp_len_q <= '0;
			for (int i = 0; i < FRAME_KEEP_L; i++) begin
				fb_q[i] <= '0;
			end
			band_q    <= '0;
			rxch_q    <= '0;
			rssi_q    <= '0;
			batt_q    <= '0;
			bad_cnt_q <= '0;
			unk_cnt_q <= '0;
		end else if (step) begin
			if (resync) begin
				idx_q <= '0;
				sum_q <= '0;
			end else begin
				exp_len_q <= exp_len_d;
				prev_q    <= byte_s1;
				if (at_chk) begin
					idx_q <= '0;
					sum_q <= '0;
				end else begin
					if (idx_q < 6'(FRAME_KEEP_L)) begin
						fb_q[idx_q[2:0]] <= byte_s1;
					end
					idx_q <= idx_q + 6'd1;
					sum_q <= sum_q + byte_s1;
				end
			end
			band_q    <= band_d;
			rxch_q    <= rxch_d;
			rssi_q    <= rssi_d;
			batt_q    <= batt_d;
			bad_cnt_q <= bad_cnt_d;
			unk_cnt_q <= unk_cnt_d;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= byte_valid_s1;
		end
	end

	logic [2:0]         status_q;
	logic [3:0]         first_q;
	logic signed [12:0] cha_q, chb_q;
	logic [7:0]         band_out_q, rxch_out_q, rssi_out_q, batt_out_q;
	logic               sig_ok_q;
	logic [31:0]        bad_out_q, unk_out_q;

	always_ff @(posedge clk) begin
		if (step) begin
			status_q   <= 3'(status_d);
			first_q    <= is_servo ? hdr[3:0] : 4'd0;
			cha_q      <= is_servo ? rcfp_pkg::scale_servo(fb_q[1], fb_q[2]) : 13'sd0;
			chb_q      <= is_servo ? rcfp_pkg::scale_servo(fb_q[3], fb_q[4]) : 13'sd0;
			band_out_q <= band_d;
			rxch_out_q <= rxch_d;
			rssi_out_q <= rssi_d;
			batt_out_q <= batt_d;
			sig_ok_q   <= (rssi_d > rssi_thr_q);
			bad_out_q  <= bad_cnt_d;
			unk_out_q  <= unk_cnt_d;
		end
	end

	assign result.valid               = res_valid_q;
	assign result.frame_status        = status_q;
	assign result.first_channel       = first_q;
	assign result.channel_a           = cha_q;
	assign result.channel_b           = chb_q;
	assign result.band_allocation     = band_out_q;
	assign result.receiver_channel    = rxch_out_q;
	assign result.signal_strength     = rssi_out_q;
	assign result.battery_level       = batt_out_q;
	assign result.signal_ok           = sig_ok_q;
	assign result.bad_checksum_count  = bad_out_q;
	assign result.unknown_frame_count = unk_out_q;

	// Checks
	a_servo_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && status_q != 3'(rcfp_pkg::ST_SERVO))
		|-> (first_q == 4'd0 && cha_q == 13'sd0 && chb_q == 13'sd0))
		else $error("pair fields set on a non-servo result");

	a_bad_count_source: assert property (@(posedge clk) disable iff (!arst_n)
		(bad_cnt_q != $past(bad_cnt_q))
		|-> (res_valid_q && status_q == 3'(rcfp_pkg::ST_CHKSUM)))
		else $error("checksum counter moved without a checksum error result");

	a_no_byte_drop: assert property (@(posedge clk) disable iff (!arst_n)
		!rx.ready |-> (byte_valid_s1 && res_valid_q))
		else $error("byte request refused with a free stage");

endmodule

// File: tb/rc_receiver_frame_parser_top_tb.sv
// ----------------------------------------------------------------------------
// rc_receiver_frame_parser_top_tb
// Self-checking bench for the receiver frame parser. A directed byte stream
// hits the framing corner cases, then random traffic of mostly well-formed
// status, servo, scan and unknown frames, mixed with noise and corrupted
// checksums, is pushed through while both sides stall at random. A built-in
// parser model predicts every result request, and the results are compared
// field by field. The RSSI threshold is rewritten between traffic phases.
// ----------------------------------------------------------------------------
module rc_receiver_frame_parser_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int          CYCLE_LIMIT = 400000;
	localparam int          HOLD_AT     = 150;
	localparam int          HOLD_CYCLES = 120;
	localparam int          PHASE_BYTES = 250;
	localparam int          SERVO_SPAN  = 2048;
	localparam logic [15:0] CLAMP_EDGE  = 16'd3078;

	typedef struct {
		rcfp_pkg::frame_status_t status;
		logic [3:0]         first;
		logic signed [12:0] ch_a;
		logic signed [12:0] ch_b;
		logic [7:0]         band;
		logic [7:0]         rx_chan;
		logic [7:0]         rssi;
		logic [7:0]         batt;
		logic               sig_ok;
		logic [31:0]        bad_cnt;
		logic [31:0]        unk_cnt;
	} parser_out_t;

	bit         clk;
	logic       arst_n;
	logic       cfg_we;
	logic [7:0] cfg_wdata;

	rcfp_byte_if   rx_if();
	rcfp_result_if res_if();

	rc_receiver_frame_parser_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx        (rx_if),
		.result    (res_if),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// Parser model state
	logic [7:0]  prev_rx_byte;
	logic [5:0]  pos;
	logic [7:0]  sum_acc;
	logic [5:0]  frame_len;
	logic [7:0]  held [rcfp_pkg::FRAME_KEEP];
	logic [7:0]  band_q, rxch_q, rssi_q, batt_q;
	logic [31:0] bad_sums, unknown_frames;
	logic [7:0]  rssi_thr;

	// Traffic and scoreboard
	logic [7:0]  rx_bytes [$];
	logic [7:0]  frame_buf [$];
	parser_out_t due_outputs [$];
	int          queued_total, bytes_in, results_seen, errors, thr_settings;
	int          idle_pct, gap_left, stall_left, hold_left, cycle_count;
	int          status_hits [8];
	bit          calm, hold_done, byte_taken;
	logic [5:0]  gen_len;

	// Offset from neutral, divide by 6 toward zero, times 4, clamp
	function automatic logic signed [12:0] servo_value(input logic [7:0] hi,
	                                                   input logic [7:0] lo);
		logic [15:0] off;
		int          v;
		off = {hi, lo} - rcfp_pkg::SERVO_NEUTRAL;
		v = $signed(off);
		v = (v / 6) * 4;
		if (v > SERVO_SPAN)
			v = SERVO_SPAN;
		else if (v < -SERVO_SPAN)
			v = -SERVO_SPAN;
		return v[12:0];
	endfunction

	// One byte through the parser model; returns the result it causes
	function automatic parser_out_t parse_rx_byte(input logic [7:0] b);
		parser_out_t r;
		logic [7:0]  chk;
		logic [7:0]  hdr;
		r.status = rcfp_pkg::ST_NONE;
		r.first  = '0;
		r.ch_a   = '0;
		r.ch_b   = '0;
		if (b == rcfp_pkg::SYNC_BYTE && prev_rx_byte == rcfp_pkg::SYNC_BYTE) begin
			// resync: previous byte is left as it was
			pos = '0;
			sum_acc = '0;
		end else begin
			// header sets the length; unknown headers keep the old one
			if (pos == 0) begin
				if (b == rcfp_pkg::HDR_STATUS)
					frame_len = rcfp_pkg::LEN_STATUS;
				else if ((b & rcfp_pkg::HDR_TYPE_MSK) == rcfp_pkg::HDR_SERVO)
					frame_len = rcfp_pkg::LEN_SERVO;
				else if (b == rcfp_pkg::HDR_SCAN)
					frame_len = rcfp_pkg::LEN_SCAN;
			end
			if (b != rcfp_pkg::SYNC_BYTE && pos > frame_len) begin
				chk = ~sum_acc;
				if (chk == rcfp_pkg::SYNC_BYTE)
					chk = rcfp_pkg::SUM_ALT;
				if (b == chk) begin
					hdr = held[0];
					if (hdr == rcfp_pkg::HDR_STATUS) begin
						band_q = held[1];
						rxch_q = held[2];
						rssi_q = held[3];
						batt_q = held[4];
						r.status = rcfp_pkg::ST_STATUS;
					end else if ((hdr & rcfp_pkg::HDR_TYPE_MSK) == rcfp_pkg::HDR_SERVO) begin
						if (hdr[3:0] < rcfp_pkg::PAIR_COUNT) begin
							r.status = rcfp_pkg::ST_SERVO;
							r.first  = hdr[3:0];
							r.ch_a   = servo_value(held[1], held[2]);
							r.ch_b   = servo_value(held[3], held[4]);
						end else begin
							r.status = rcfp_pkg::ST_RANGE;
						end
					end else begin
						unknown_frames++;
						r.status = rcfp_pkg::ST_UNKNOWN;
					end
				end else begin
					bad_sums++;
					r.status = rcfp_pkg::ST_CHKSUM;
				end
				pos = '0;
				sum_acc = '0;
			end else begin
				// only the first five bytes are kept, all enter the sum
				if (pos < rcfp_pkg::FRAME_KEEP)
					held[pos] = b;
				pos = pos + 6'd1;
				sum_acc = sum_acc + b;
			end
			prev_rx_byte = b;
		end
		r.band    = band_q;
		r.rx_chan = rxch_q;
		r.rssi    = rssi_q;
		r.batt    = batt_q;
		r.sig_ok  = rssi_q > rssi_thr;
		r.bad_cnt = bad_sums;
		r.unk_cnt = unknown_frames;
		return r;
	endfunction

	task automatic field_err(input string name, input longint want, input longint got);
		errors++;
		$display("[%0t] %s: expected %0d, actual %0d", $time, name, want, got);
	endtask

	task automatic put_byte(input logic [7:0] b);
		rx_bytes.push_back(b);
		queued_total++;
	endtask

	task automatic add_random(input int n);
		repeat (n) frame_buf.push_back(8'($urandom_range(0, 255)));
	endtask

	// Servo word: near neutral mostly, some full range, some clamp edges
	function automatic logic [15:0] servo_word();
		logic [15:0] w;
		case ($urandom_range(0, 3))
			0: w = 16'($urandom_range(0, 65535));
			1, 2: w = rcfp_pkg::SERVO_NEUTRAL + 16'($urandom_range(0, 6400)) - 16'd3200;
			default: begin
				case ($urandom_range(0, 5))
					0: w = 16'h0000;
					1: w = 16'hFFFE;
					2: w = rcfp_pkg::SERVO_NEUTRAL + CLAMP_EDGE - 16'd1;
					3: w = rcfp_pkg::SERVO_NEUTRAL + CLAMP_EDGE;
					4: w = rcfp_pkg::SERVO_NEUTRAL - CLAMP_EDGE + 16'd1;
					default: w = rcfp_pkg::SERVO_NEUTRAL - CLAMP_EDGE;
				endcase
			end
		endcase
		return w;
	endfunction

	task automatic add_word(input logic [15:0] w);
		frame_buf.push_back(w[15:8]);
		frame_buf.push_back(w[7:0]);
	endtask

	// Queue the frame in frame_buf plus its checksum, optionally corrupted
	task automatic send_frame(input bit corrupt);
		logic [7:0] acc;
		logic [7:0] chk;
		logic [7:0] flip;
		acc = '0;
		// two sync bytes in a row would resync mid-frame
		for (int i = 1; i < frame_buf.size(); i++)
			if (frame_buf[i - 1] == rcfp_pkg::SYNC_BYTE && frame_buf[i] == rcfp_pkg::SYNC_BYTE)
				frame_buf[i] = rcfp_pkg::SUM_ALT;
		foreach (frame_buf[i]) begin
			acc = acc + frame_buf[i];
			put_byte(frame_buf[i]);
		end
		chk = ~acc;
		if (chk == rcfp_pkg::SYNC_BYTE)
			chk = rcfp_pkg::SUM_ALT;
		if (corrupt) begin
			do
				flip = 8'($urandom_range(1, 255));
			while ((chk ^ flip) == rcfp_pkg::SYNC_BYTE);
			chk = chk ^ flip;
		end
		put_byte(chk);
		frame_buf.delete();
	endtask

	// Mostly well-formed frames, some noise and broken checksums
	task automatic random_traffic(input int n);
		int         start;
		int         pick;
		bit         bad;
		logic [7:0] h;
		start = queued_total;
		while (queued_total - start < n) begin
			pick = $urandom_range(0, 99);
			bad = ($urandom_range(0, 9) == 0);
			if (pick < 25) begin
				// status frame, RSSI often right at the threshold
				frame_buf.push_back(rcfp_pkg::HDR_STATUS);
				add_random(2);
				case ($urandom_range(0, 2))
					0: frame_buf.push_back(8'($urandom_range(0, 255)));
					1: frame_buf.push_back(rssi_thr);
					default: frame_buf.push_back(rssi_thr + 8'd1);
				endcase
				add_random(2);
				gen_len = rcfp_pkg::LEN_STATUS;
				send_frame(bad);
			end else if (pick < 60) begin
				frame_buf.push_back(rcfp_pkg::HDR_SERVO | 8'($urandom_range(0, 9)));
				add_word(servo_word());
				add_word(servo_word());
				gen_len = rcfp_pkg::LEN_SERVO;
				send_frame(bad);
			end else if (pick < 68) begin
				frame_buf.push_back(rcfp_pkg::HDR_SERVO | 8'($urandom_range(10, 15)));
				add_random(4);
				gen_len = rcfp_pkg::LEN_SERVO;
				send_frame(bad);
			end else if (pick < 72) begin
				frame_buf.push_back(rcfp_pkg::HDR_SCAN);
				add_random(rcfp_pkg::LEN_SCAN);
				gen_len = rcfp_pkg::LEN_SCAN;
				send_frame($urandom_range(0, 1));
			end else if (pick < 80) begin
				do
					h = 8'($urandom_range(0, 254));
				while (h == rcfp_pkg::HDR_SCAN
				       || (h & rcfp_pkg::HDR_TYPE_MSK) == rcfp_pkg::HDR_SERVO);
				frame_buf.push_back(h);
				add_random(gen_len);
				send_frame(bad);
			end else if (pick < 90) begin
				// line noise, then resync
				repeat ($urandom_range(1, 6)) put_byte(8'($urandom_range(0, 255)));
				put_byte(rcfp_pkg::SYNC_BYTE);
				put_byte(rcfp_pkg::SYNC_BYTE);
			end else begin
				// sync byte where the checksum would go
				frame_buf.push_back(rcfp_pkg::HDR_SERVO | 8'($urandom_range(0, 15)));
				add_word(servo_word());
				add_word(servo_word());
				frame_buf.push_back(rcfp_pkg::SYNC_BYTE);
				gen_len = rcfp_pkg::LEN_SERVO;
				send_frame(bad);
			end
		end
	endtask

	// Wait until every byte is taken and every result has come back
	task automatic drain();
		@(negedge clk);
		while (rx_bytes.size() != 0 || rx_if.valid || due_outputs.size() != 0)
			@(negedge clk);
	endtask

	task automatic set_threshold(input logic [7:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		rssi_thr = v;
		thr_settings++;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Clock
	initial begin
		forever #2 clk = ~clk;
	end

	// Run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[%0t] timeout after %0d cycles", $time, cycle_count);
			$display("rc_receiver_frame_parser_top regression: fail");
			$finish;
		end
	end

	// Byte request driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (!rx_if.valid || byte_taken) begin
				if (gap_left > 0) begin
					gap_left--;
					rx_if.valid <= 1'b0;
				end else if (rx_bytes.size() == 0) begin
					rx_if.valid <= 1'b0;
				end else if (!calm && $urandom_range(0, 99) < idle_pct) begin
					gap_left = $urandom_range(1, 13) - 1;
					rx_if.valid <= 1'b0;
				end else begin
					rx_if.valid <= 1'b1;
					rx_if.data_byte <= rx_bytes.pop_front();
				end
			end
			byte_taken = 1'b0;
		end
	end

	// Result ready: random stalls plus one long hold-off to back up the input
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_left > 0) begin
				hold_left--;
				res_if.ready <= 1'b0;
			end else if (!hold_done && results_seen >= HOLD_AT) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES - 1;
				res_if.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				res_if.ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 99) < idle_pct) begin
				stall_left = $urandom_range(1, 13) - 1;
				res_if.ready <= 1'b0;
			end else begin
				res_if.ready <= 1'b1;
			end
		end
	end

	// Monitor: predict on each byte request, check each result request
	always @(posedge clk) begin
		parser_out_t e;
		if (arst_n) begin
			if (rx_if.valid && rx_if.ready) begin
				due_outputs.push_back(parse_rx_byte(rx_if.data_byte));
				byte_taken = 1'b1;
				bytes_in++;
			end
			if (res_if.valid && res_if.ready) begin
				results_seen++;
				status_hits[res_if.frame_status]++;
				if (due_outputs.size() == 0) begin
					errors++;
					$display("[%0t] result with nothing expected: frame_status %0d",
					         $time, res_if.frame_status);
				end else begin
					e = due_outputs.pop_front();
					if (e.status !== res_if.frame_status)
						field_err("frame_status", e.status, res_if.frame_status);
					if (e.first !== res_if.first_channel)
						field_err("first_channel", e.first, res_if.first_channel);
					if (e.ch_a !== res_if.channel_a)
						field_err("channel_a", e.ch_a, res_if.channel_a);
					if (e.ch_b !== res_if.channel_b)
						field_err("channel_b", e.ch_b, res_if.channel_b);
					if (e.band !== res_if.band_allocation)
						field_err("band_allocation", e.band, res_if.band_allocation);
					if (e.rx_chan !== res_if.receiver_channel)
						field_err("receiver_channel", e.rx_chan, res_if.receiver_channel);
					if (e.rssi !== res_if.signal_strength)
						field_err("signal_strength", e.rssi, res_if.signal_strength);
					if (e.batt !== res_if.battery_level)
						field_err("battery_level", e.batt, res_if.battery_level);
					if (e.sig_ok !== res_if.signal_ok)
						field_err("signal_ok", e.sig_ok, res_if.signal_ok);
					if (e.bad_cnt !== res_if.bad_checksum_count)
						field_err("bad_checksum_count", e.bad_cnt, res_if.bad_checksum_count);
					if (e.unk_cnt !== res_if.unknown_frame_count)
						field_err("unknown_frame_count", e.unk_cnt,
						          res_if.unknown_frame_count);
				end
			end
		end
	end

	// Stimulus and phase control
	initial begin
		// known levels and model reset state from time zero
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		rx_if.valid = 1'b0;
		rx_if.data_byte = '0;
		res_if.ready = 1'b0;
		prev_rx_byte = '0;
		pos = '0;
		sum_acc = '0;
		frame_len = '0;
		foreach (held[i]) held[i] = '0;
		band_q = '0;
		rxch_q = '0;
		rssi_q = '0;
		batt_q = '0;
		bad_sums = '0;
		unknown_frames = '0;
		rssi_thr = rcfp_pkg::RSSI_THR_RESET;
		gen_len = '0;
		idle_pct = 20;

		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		// length still zero after reset: header then a wrong checksum
		put_byte(8'h00);
		put_byte(8'h42);
		// resync
		put_byte(rcfp_pkg::SYNC_BYTE);
		put_byte(rcfp_pkg::SYNC_BYTE);
		// status frame with extreme stored values and a sixth frame byte
		frame_buf = '{rcfp_pkg::HDR_STATUS, 8'h00, rcfp_pkg::SYNC_BYTE, 8'h08,
		              rcfp_pkg::SYNC_BYTE, 8'h80};
		send_frame(1'b0);
		// last servo pair, words at the bottom and top of the range
		frame_buf = '{8'h19, 8'h00, 8'h00, rcfp_pkg::SYNC_BYTE, 8'hFE};
		send_frame(1'b0);
		// pair ten, sync byte sitting in the checksum slot
		frame_buf = '{8'h1A, 8'h2B, 8'h33, 8'h37, 8'h39, rcfp_pkg::SYNC_BYTE};
		send_frame(1'b0);
		// unknown header keeps the servo length; byte sum zero gives 0xFE
		frame_buf = '{8'h55, 8'h01, 8'h02, 8'h03, 8'hA5};
		send_frame(1'b0);
		gen_len = rcfp_pkg::LEN_SERVO;
		random_traffic(PHASE_BYTES);

		for (int k = 0; k < 4; k++) begin
			drain();
			case (k)
				0: begin
					idle_pct = 0;
					set_threshold(8'h00);
				end
				1: begin
					idle_pct = 35;
					set_threshold(8'hFF);
				end
				2: begin
					idle_pct = 10;
					set_threshold(8'($urandom_range(1, 254)));
				end
				default: begin
					calm = 1'b1;
					set_threshold(8'($urandom_range(0, 255)));
				end
			endcase
			random_traffic(PHASE_BYTES);
		end

		drain();
		repeat (4) @(posedge clk);

		$display("covered %0d bytes and %0d results over %0d threshold settings",
		         bytes_in, results_seen, thr_settings + 1);
		$display("frames: %0d status, %0d servo, %0d pair out of range, %0d unknown, %0d bad sum",
		         status_hits[rcfp_pkg::ST_STATUS], status_hits[rcfp_pkg::ST_SERVO],
		         status_hits[rcfp_pkg::ST_RANGE], status_hits[rcfp_pkg::ST_UNKNOWN],
		         status_hits[rcfp_pkg::ST_CHKSUM]);
		if (errors == 0)
			$display("rc_receiver_frame_parser_top regression: pass");
		else
			$display("rc_receiver_frame_parser_top regression: fail");
		$finish;
	end

endmodule
